FILE: sv/dmip_pkg.sv
// ----------------------------------------------------------------------------
// dmip_pkg
// Shared types, constants and microcode for the two-motor incremental PID.
// ----------------------------------------------------------------------------
package dmip_pkg;

  localparam int GAIN_FRAC_BITS     = 4;
  localparam int STRAIGHT_COUNT_CAP = 30;
  localparam int CNT_W              = $clog2(STRAIGHT_COUNT_CAP + 1);
  localparam int STRAIGHT_RUN_MIN   = 7;
  localparam int STRAIGHT_THRESHOLD = 10;
  localparam int DIFF_THRESHOLD     = 10;

  localparam logic signed [15:0] STOP_DRIVE      = -16'sd500;
  localparam logic signed [15:0] OPEN_LOOP_DRIVE = 16'sd4000;
  localparam logic signed [15:0] SLOW_SPEED      = 16'sd20;

  // divide by ten: reciprocal multiply, then one correction step
  localparam int             RECIP_SHIFT = 18;
  localparam int             RECIP_W     = 15;
  localparam logic [RECIP_W-1:0] RECIP_TEN = RECIP_W'((1 << RECIP_SHIFT) / 10);
  localparam int             DIV_A_W     = 19;
  localparam int             QUOT_W      = 16;

  localparam int MUL_A_W = 20;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 32;
  localparam int SAT_W   = ACC_W + 1;

  localparam logic signed [ACC_W-1:0] FRAC_BIAS = ACC_W'((1 << GAIN_FRAC_BITS) - 1);
  localparam logic signed [SAT_W-1:0] S16_MAX   = SAT_W'(32767);
  localparam logic signed [SAT_W-1:0] S16_MIN   = -SAT_W'(32768);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP, CFG_KI, CFG_KD, CFG_LIMIT, CFG_LOW, CFG_MID, CFG_HIGH
  } cfg_idx_t;

  typedef enum logic [1:0] {MODE_LOW, MODE_MID, MODE_HIGH} mode_t;

  typedef struct packed {
    logic [11:0] kp_gain;
    logic [11:0] ki_gain;
    logic [11:0] kd_gain;
    logic [14:0] drive_limit;
    logic [31:0] target_low_pair;
    logic [31:0] target_mid_pair;
    logic [31:0] target_high_pair;
  } cfg_t;

  typedef struct packed {
    logic signed [7:0]  near_error;
    logic signed [7:0]  near_error_earlier;
    logic signed [7:0]  far_error;
    logic signed [7:0]  far_error_earlier;
    logic signed [15:0] left_measured;
    logic signed [15:0] right_measured;
    logic               stop_request;
    logic               open_loop_request;
  } in_t;

  typedef struct packed {
    logic [14:0] left_forward_duty;
    logic [14:0] left_reverse_duty;
    logic [14:0] right_forward_duty;
    logic [14:0] right_reverse_duty;
    logic [1:0]  speed_mode;
  } out_t;

  // microcode fields
  typedef enum logic [2:0] {
    MUL_NONE, MUL_DIV7, MUL_DIV12, MUL_KP, MUL_KI, MUL_KD
  } mul_sel_t;
  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;
  typedef enum logic [1:0] {DW_NONE, DW_OTHER, DW_SELF} div_wr_t;
  typedef enum logic [1:0] {JC_NONE, JC_NODIFF, JC_OUTBUSY} jmp_t;

  localparam int UCODE_LEN = 18;
  localparam int PC_W      = $clog2(UCODE_LEN);

  localparam logic [PC_W-1:0] STEP_PID = PC_W'(3);
  localparam logic [PC_W-1:0] STEP_OUT = PC_W'(17);

  typedef struct packed {
    mul_sel_t        mul;
    acc_op_t         acc;
    logic            wheel;
    logic            err_en;
    logic            inc_en;
    logic            drv_en;
    div_wr_t         div_wr;
    logic            out_en;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
    logic            last;
  } uword_t;

  typedef struct packed {
    logic no_diff;
    logic out_busy;
  } status_t;

  localparam uword_t UWORD_NOP = '0;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = UWORD_NOP;
    case (pc)
      5'd0: begin
        w.mul    = MUL_DIV7;
        w.jmp    = JC_NODIFF;
        w.target = STEP_PID;
      end
      5'd1: begin
        w.mul    = MUL_DIV12;
        w.div_wr = DW_OTHER;
      end
      5'd2:  w.div_wr = DW_SELF;
      5'd3:  w.err_en = 1'b1;
      5'd4:  w.mul = MUL_KP;
      5'd5: begin
        w.mul = MUL_KI;
        w.acc = ACC_LOAD;
      end
      5'd6: begin
        w.mul = MUL_KD;
        w.acc = ACC_ADD;
      end
      5'd7:  w.acc = ACC_ADD;
      5'd8:  w.inc_en = 1'b1;
      5'd9:  w.drv_en = 1'b1;
      5'd10: begin
        w.wheel  = 1'b1;
        w.err_en = 1'b1;
      end
      5'd11: begin
        w.wheel = 1'b1;
        w.mul   = MUL_KP;
      end
      5'd12: begin
        w.wheel = 1'b1;
        w.mul   = MUL_KI;
        w.acc   = ACC_LOAD;
      end
      5'd13: begin
        w.wheel = 1'b1;
        w.mul   = MUL_KD;
        w.acc   = ACC_ADD;
      end
      5'd14: begin
        w.wheel = 1'b1;
        w.acc   = ACC_ADD;
      end
      5'd15: begin
        w.wheel  = 1'b1;
        w.inc_en = 1'b1;
      end
      5'd16: begin
        w.wheel  = 1'b1;
        w.drv_en = 1'b1;
      end
      5'd17: begin
        w.out_en = 1'b1;
        w.jmp    = JC_OUTBUSY;
        w.target = STEP_OUT;
        w.last   = 1'b1;
      end
      default: w = UWORD_NOP;
    endcase
    return w;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [SAT_W-1:0] v);
    logic signed [15:0] r;
    if (v > S16_MAX) begin
      r = 16'sh7fff;
    end else if (v < S16_MIN) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] abs8(input logic signed [7:0] v);
    logic [7:0] r;
    r = v[7] ? 8'(-v) : 8'(v);
    return r;
  endfunction

endpackage

FILE: sv/dmip_seq.sv
// ----------------------------------------------------------------------------
// dmip_seq
// Step counter over the microcode ROM with conditional jumps.
// ----------------------------------------------------------------------------
module dmip_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  dmip_pkg::status_t status,
  output logic              busy,
  output dmip_pkg::uword_t  ctrl
);
  import dmip_pkg::*;

  logic [PC_W-1:0] pc, pc_next;
  logic            busy_next;
  logic            take;
  uword_t          word;

  always_comb begin
    word = ucode(pc);
    ctrl = busy ? word : UWORD_NOP;
    case (word.jmp)
      JC_NODIFF:  take = status.no_diff;
      JC_OUTBUSY: take = status.out_busy;
      JC_NONE:    take = 1'b0;
      default:    take = 1'b0;
    endcase
    pc_next   = pc;
    busy_next = busy;
    if (start) begin
      pc_next   = '0;
      busy_next = 1'b1;
    end else if (busy) begin
      if (take) begin
        pc_next = word.target;
      end else if (word.last) begin
        pc_next   = '0;
        busy_next = 1'b0;
      end else begin
        pc_next = pc + PC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= '0;
      busy <= 1'b0;
    end else begin
      pc   <= pc_next;
      busy <= busy_next;
    end
  end

endmodule

FILE: sv/dmip_dpath.sv
// ----------------------------------------------------------------------------
// dmip_dpath
// Mode tracking, target selection, shared multiplier, PID datapath and
// output register.
// ----------------------------------------------------------------------------
module dmip_dpath (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  dmip_pkg::in_t     in_data,
  input  dmip_pkg::cfg_t    cfg,
  input  dmip_pkg::uword_t  ctrl,
  output dmip_pkg::status_t status,
  output logic              out_valid,
  input  logic              out_stall,
  output dmip_pkg::out_t    out_data
);
  import dmip_pkg::*;

  // mode state
  logic [CNT_W-1:0] near_cnt, far_cnt, near_cnt_next, far_cnt_next;
  logic             straight_mark, turn_mark, straight_next, turn_next;
  logic             sm1, tm1;
  logic [7:0]       abs_n, abs_no, abs_f, abs_fo;
  logic             near_ok, far_ok;
  mode_t            mode_next, mode_q;
  logic [31:0]      pair;

  // request payload
  logic signed [15:0] tgt_l, tgt_r, meas_l, meas_r;
  logic               stop_q, open_q, diff_pos, diff_neg;

  // PID state
  logic signed [15:0] drive_l, drive_r;
  logic signed [15:0] hist_l0, hist_l1, hist_r0, hist_r1;
  logic signed [15:0] e0;

  // datapath
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc, acc_b, inc;

  logic signed [15:0] base, e1, e2, tgt_w, meas_w, drv_cur, sum16, ov, dval;
  logic               base_neg;
  logic [15:0]        base_abs;
  logic [DIV_A_W-1:0] a7, a12, div_a;
  logic [QUOT_W-1:0]  q0;
  logic [DIV_A_W:0]   rem;
  logic [QUOT_W:0]    qf;
  logic signed [QUOT_W+1:0] qs;
  logic signed [15:0] qsat;
  logic signed [16:0] d1, lim, ov17;
  logic signed [17:0] d2;

  logic               out_busy, slow;
  logic signed [15:0] neg_l, neg_r;
  out_t               out_next;

  // straight/turn tracking on the incoming request
  always_comb begin
    abs_n   = abs8(in_data.near_error);
    abs_no  = abs8(in_data.near_error_earlier);
    abs_f   = abs8(in_data.far_error);
    abs_fo  = abs8(in_data.far_error_earlier);
    near_ok = abs_n <= 8'(STRAIGHT_THRESHOLD);
    far_ok  = abs_f <= 8'(STRAIGHT_THRESHOLD);

    near_cnt_next = near_cnt;
    far_cnt_next  = far_cnt;
    if (near_ok) begin
      if (near_cnt < CNT_W'(STRAIGHT_COUNT_CAP)) near_cnt_next = near_cnt + CNT_W'(1);
      if (far_ok) begin
        if (far_cnt < CNT_W'(STRAIGHT_COUNT_CAP)) far_cnt_next = far_cnt + CNT_W'(1);
      end else begin
        far_cnt_next = '0;
      end
    end else begin
      near_cnt_next = '0;
    end

    sm1 = straight_mark;
    tm1 = turn_mark;
    if (far_cnt_next > CNT_W'(STRAIGHT_RUN_MIN) && !straight_mark &&
        near_cnt_next > CNT_W'(STRAIGHT_RUN_MIN)) begin
      sm1 = 1'b1;
      tm1 = 1'b0;
    end
    straight_next = sm1;
    turn_next     = tm1;
    if (sm1 && !tm1 &&
        ((abs_n >= 8'(STRAIGHT_THRESHOLD) && abs_no >= 8'(STRAIGHT_THRESHOLD)) ||
         (abs_f >= 8'(STRAIGHT_THRESHOLD) && abs_fo >= 8'(STRAIGHT_THRESHOLD)))) begin
      straight_next = 1'b0;
      turn_next     = 1'b1;
    end

    if (straight_next) begin
      pair      = cfg.target_high_pair;
      mode_next = MODE_HIGH;
    end else if (turn_next) begin
      pair      = cfg.target_mid_pair;
      mode_next = MODE_MID;
    end else begin
      pair      = cfg.target_low_pair;
      mode_next = MODE_LOW;
    end
  end

  // differential: |base| * 7 or 12, then divide by ten
  always_comb begin
    base     = diff_pos ? tgt_l : tgt_r;
    base_neg = base[15];
    base_abs = base_neg ? 16'(-base) : 16'(base);
    a7       = (DIV_A_W'(base_abs) << 3) - DIV_A_W'(base_abs);
    a12      = (DIV_A_W'(base_abs) << 3) + (DIV_A_W'(base_abs) << 2);
    div_a    = (ctrl.div_wr == DW_OTHER) ? a7 : a12;
    q0       = prod[RECIP_SHIFT +: QUOT_W];
    rem      = (DIV_A_W+1)'(div_a) - ((DIV_A_W+1)'(q0) << 3) - ((DIV_A_W+1)'(q0) << 1);
    qf       = (QUOT_W+1)'(q0) + ((rem >= (DIV_A_W+1)'(10)) ? (QUOT_W+1)'(1) : '0);
    qs       = base_neg ? -$signed({1'b0, qf}) : $signed({1'b0, qf});
    qsat     = sat16(SAT_W'(qs));
  end

  // multiplier operands and PID terms
  always_comb begin
    e1     = ctrl.wheel ? hist_r0 : hist_l0;
    e2     = ctrl.wheel ? hist_r1 : hist_l1;
    d1     = 17'(e0) - 17'(e1);
    d2     = 18'(e0) - (18'(e1) <<< 1) + 18'(e2);
    tgt_w  = ctrl.wheel ? tgt_r : tgt_l;
    meas_w = ctrl.wheel ? meas_r : meas_l;
    case (ctrl.mul)
      MUL_DIV7: begin
        mul_a = $signed(MUL_A_W'(a7));
        mul_b = $signed(MUL_B_W'(RECIP_TEN));
      end
      MUL_DIV12: begin
        mul_a = $signed(MUL_A_W'(a12));
        mul_b = $signed(MUL_B_W'(RECIP_TEN));
      end
      MUL_KP: begin
        mul_a = MUL_A_W'(d1);
        mul_b = $signed(MUL_B_W'(cfg.kp_gain));
      end
      MUL_KI: begin
        mul_a = MUL_A_W'(e0);
        mul_b = $signed(MUL_B_W'(cfg.ki_gain));
      end
      MUL_KD: begin
        mul_a = MUL_A_W'(d2);
        mul_b = $signed(MUL_B_W'(cfg.kd_gain));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase

    acc_b   = acc + (acc[ACC_W-1] ? FRAC_BIAS : '0);
    drv_cur = ctrl.wheel ? drive_r : drive_l;
    sum16   = sat16(SAT_W'(drv_cur) + SAT_W'(inc));
    if (open_q) begin
      ov = OPEN_LOOP_DRIVE;
    end else if (stop_q) begin
      ov = STOP_DRIVE;
    end else begin
      ov = sum16;
    end
    lim  = $signed({2'b00, cfg.drive_limit});
    ov17 = 17'(ov);
    if (ov17 > lim) begin
      dval = lim[15:0];
    end else if (ov17 < -lim) begin
      dval = 16'(-lim);
    end else begin
      dval = ov;
    end
  end

  // result assembly
  always_comb begin
    out_busy = out_valid && out_stall;
    slow     = (meas_l < SLOW_SPEED) && (meas_r < SLOW_SPEED);
    neg_l    = -drive_l;
    neg_r    = -drive_r;
    out_next = '0;
    if (!slow) begin
      if (drive_l > 16'sd0) out_next.left_forward_duty = drive_l[14:0];
      else out_next.left_reverse_duty = neg_l[14:0];
      if (drive_r > 16'sd0) out_next.right_forward_duty = drive_r[14:0];
      else out_next.right_reverse_duty = neg_r[14:0];
    end
    out_next.speed_mode = mode_q;
    status.no_diff  = !(diff_pos || diff_neg);
    status.out_busy = out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      near_cnt      <= '0;
      far_cnt       <= '0;
      straight_mark <= 1'b0;
      turn_mark     <= 1'b0;
      drive_l       <= '0;
      drive_r       <= '0;
      hist_l0       <= '0;
      hist_l1       <= '0;
      hist_r0       <= '0;
      hist_r1       <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (start) begin
        near_cnt      <= near_cnt_next;
        far_cnt       <= far_cnt_next;
        straight_mark <= straight_next;
        turn_mark     <= turn_next;
      end
      if (ctrl.drv_en) begin
        if (ctrl.wheel) begin
          drive_r <= dval;
          hist_r1 <= hist_r0;
          hist_r0 <= e0;
        end else begin
          drive_l <= dval;
          hist_l1 <= hist_l0;
          hist_l0 <= e0;
        end
      end
      if (ctrl.out_en && !out_busy) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode_q   <= mode_next;
      tgt_l    <= $signed(pair[15:0]);
      tgt_r    <= $signed(pair[31:16]);
      meas_l   <= in_data.left_measured;
      meas_r   <= in_data.right_measured;
      stop_q   <= in_data.stop_request;
      open_q   <= in_data.open_loop_request;
      diff_pos <= in_data.far_error > 8'(DIFF_THRESHOLD);
      diff_neg <= in_data.far_error < -8'(DIFF_THRESHOLD);
    end
    case (ctrl.div_wr)
      DW_OTHER: begin
        if (diff_pos) tgt_r <= qsat;
        else tgt_l <= qsat;
      end
      DW_SELF: begin
        if (diff_pos) tgt_l <= qsat;
        else tgt_r <= qsat;
      end
      default: ;
    endcase
    if (ctrl.mul != MUL_NONE) prod <= mul_a * mul_b;
    case (ctrl.acc)
      ACC_LOAD: acc <= ACC_W'(prod);
      ACC_ADD:  acc <= acc + ACC_W'(prod);
      default:  ;
    endcase
    if (ctrl.err_en) e0 <= sat16(SAT_W'(tgt_w) - SAT_W'(meas_w));
    if (ctrl.inc_en) inc <= acc_b >>> GAIN_FRAC_BITS;
    if (ctrl.out_en && !out_busy) out_data <= out_next;
  end

endmodule

FILE: sv/dual_motor_incremental_pid.sv
// ----------------------------------------------------------------------------
// dual_motor_incremental_pid
// Two-wheel incremental PID speed controller with track-based target modes.
// ----------------------------------------------------------------------------
// One request per control tick. After a request is taken, a microcoded
// sequencer runs a shared 20x17 multiplier and accumulator through the
// left and right PID updates, with two extra multiply/divide-by-ten steps
// when the far error exceeds +-10 and the differential targets are needed.
// A new request is taken the cycle after the sequence ends; the last step
// waits while the output register still holds an untaken result.
// Configuration writes are single-cycle and should only be issued while
// idle.
module dual_motor_incremental_pid (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  dmip_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output dmip_pkg::out_t                     out_data,
  input  logic                               cfg_write,
  input  logic [dmip_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dmip_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import dmip_pkg::*;

  cfg_t    cfg;
  uword_t  ctrl;
  status_t status;
  logic    busy, start;

  assign in_stall = busy;
  assign start    = in_valid && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp_gain          <= 12'd480;
      cfg.ki_gain          <= 12'd96;
      cfg.kd_gain          <= 12'd0;
      cfg.drive_limit      <= 15'd9000;
      cfg.target_low_pair  <= '0;
      cfg.target_mid_pair  <= '0;
      cfg.target_high_pair <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_KP:    cfg.kp_gain          <= cfg_data[11:0];
        CFG_KI:    cfg.ki_gain          <= cfg_data[11:0];
        CFG_KD:    cfg.kd_gain          <= cfg_data[11:0];
        CFG_LIMIT: cfg.drive_limit      <= cfg_data[14:0];
        CFG_LOW:   cfg.target_low_pair  <= cfg_data;
        CFG_MID:   cfg.target_mid_pair  <= cfg_data;
        CFG_HIGH:  cfg.target_high_pair <= cfg_data;
        default:   ;
      endcase
    end
  end

  dmip_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .ctrl   (ctrl)
  );

  dmip_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .in_data   (in_data),
    .cfg       (cfg),
    .ctrl      (ctrl),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("sequencer not busy after request accept");

  a_result_from_sequence: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result produced without a running sequence");

  a_one_direction: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.left_forward_duty != 15'd0 &&
                    out_data.left_reverse_duty != 15'd0) &&
                  !(out_data.right_forward_duty != 15'd0 &&
                    out_data.right_reverse_duty != 15'd0))
    else $error("forward and reverse duty both active");

endmodule

FILE: test/dual_motor_incremental_pid_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_motor_incremental_pid_tb
// Self-checking bench for the two-motor incremental PID speed controller.
// ----------------------------------------------------------------------------
// A short table of directed control ticks is followed by random ticks built
// as straight runs and curve bursts, so the speed mode walks through low,
// high and mid. Each accepted request is run through a local model of the
// target selection, differential and PID update. Each result is compared
// field by field. Phases change the gains, limit and targets between
// drained runs, and vary sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module dual_motor_incremental_pid_tb;
  import dmip_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_TICKS = 235;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dual_motor_incremental_pid i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // controller model state
  cfg_t               ctl;
  logic signed [15:0] left_drv, right_drv;
  logic signed [15:0] left_e_last, left_e_prev, right_e_last, right_e_prev;
  logic [4:0]         near_run, far_run;
  bit                 straight_on, turn_on;

  out_t expected_duties[$];
  int   mismatch_cnt = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   holds_asked = 0;
  int   holds_served = 0;

  // random tick shaping
  int                gen_straight_left = 0;
  int                gen_curve_left = 3;
  logic signed [7:0] gen_last_near = '0;
  logic signed [7:0] gen_last_far = '0;

  typedef struct {
    in_t  req;
    bit   typed;
    out_t want;
  } tick_row_t;

  tick_row_t tick_rows[$];

  function automatic longint clip16(input longint v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  function automatic int mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic signed [15:0] pid_step(input logic signed [15:0] drv,
                                                  inout logic signed [15:0] e_last,
                                                  inout logic signed [15:0] e_prev,
                                                  input longint tgt, input longint meas);
    longint e0, e1, e2, sum;
    e0 = clip16(tgt - meas);
    e1 = e_last;
    e2 = e_prev;
    sum = longint'(ctl.kp_gain) * (e0 - e1) + longint'(ctl.ki_gain) * e0
        + longint'(ctl.kd_gain) * (e0 - 2 * e1 + e2);
    e_prev = e_last;
    e_last = 16'(e0);
    return 16'(clip16(longint'(drv) + sum / (longint'(1) << GAIN_FRAC_BITS)));
  endfunction

  function automatic logic signed [15:0] limit_drive(input logic signed [15:0] d);
    int lim, v;
    lim = int'(ctl.drive_limit);
    v = d;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return 16'(v);
  endfunction

  function automatic out_t next_duties(input in_t r);
    int          near, near_old, far, far_old, lm, rm;
    longint      lt, rt;
    logic [31:0] pair;
    mode_t       mode;
    out_t        o;
    near = r.near_error;
    near_old = r.near_error_earlier;
    far = r.far_error;
    far_old = r.far_error_earlier;
    lm = r.left_measured;
    rm = r.right_measured;

    if (mag(near) <= STRAIGHT_THRESHOLD) begin
      if (near_run < STRAIGHT_COUNT_CAP) near_run++;
      if (mag(far) <= STRAIGHT_THRESHOLD) begin
        if (far_run < STRAIGHT_COUNT_CAP) far_run++;
      end else begin
        far_run = '0;
      end
    end else begin
      near_run = '0;
    end
    if (far_run > STRAIGHT_RUN_MIN && !straight_on && near_run > STRAIGHT_RUN_MIN) begin
      straight_on = 1'b1;
      turn_on = 1'b0;
    end
    if (straight_on && !turn_on &&
        ((mag(near) >= STRAIGHT_THRESHOLD && mag(near_old) >= STRAIGHT_THRESHOLD) ||
         (mag(far) >= STRAIGHT_THRESHOLD && mag(far_old) >= STRAIGHT_THRESHOLD))) begin
      turn_on = 1'b1;
      straight_on = 1'b0;
    end
    if (straight_on) begin
      pair = ctl.target_high_pair;
      mode = MODE_HIGH;
    end else if (turn_on) begin
      pair = ctl.target_mid_pair;
      mode = MODE_MID;
    end else begin
      pair = ctl.target_low_pair;
      mode = MODE_LOW;
    end
    lt = longint'($signed(pair[15:0]));
    rt = longint'($signed(pair[31:16]));

    // differential: truncated toward zero
    if (far > DIFF_THRESHOLD) begin
      rt = clip16((lt * 7) / 10);
      lt = clip16((lt * 12) / 10);
    end else if (far < -DIFF_THRESHOLD) begin
      lt = clip16((rt * 7) / 10);
      rt = clip16((rt * 12) / 10);
    end

    left_drv = pid_step(left_drv, left_e_last, left_e_prev, lt, lm);
    right_drv = pid_step(right_drv, right_e_last, right_e_prev, rt, rm);
    if (r.stop_request) begin
      left_drv = STOP_DRIVE;
      right_drv = STOP_DRIVE;
    end
    if (r.open_loop_request) begin
      left_drv = OPEN_LOOP_DRIVE;
      right_drv = OPEN_LOOP_DRIVE;
    end
    left_drv = limit_drive(left_drv);
    right_drv = limit_drive(right_drv);

    o = '0;
    o.speed_mode = mode;
    if (!(lm < SLOW_SPEED && rm < SLOW_SPEED)) begin
      if (left_drv > 0) o.left_forward_duty = left_drv[14:0];
      else o.left_reverse_duty = 15'(-int'(left_drv));
      if (right_drv > 0) o.right_forward_duty = right_drv[14:0];
      else o.right_reverse_duty = 15'(-int'(right_drv));
    end
    return o;
  endfunction

  function automatic in_t mk(input int near, input int near_old, input int far,
                             input int far_old, input int lm, input int rm,
                             input bit stop, input bit open_loop);
    in_t r;
    r.near_error = 8'(near);
    r.near_error_earlier = 8'(near_old);
    r.far_error = 8'(far);
    r.far_error_earlier = 8'(far_old);
    r.left_measured = 16'(lm);
    r.right_measured = 16'(rm);
    r.stop_request = stop;
    r.open_loop_request = open_loop;
    return r;
  endfunction

  // mostly straight runs and curve bursts, with some raw noise
  function automatic in_t rand_req();
    in_t         r;
    logic [95:0] raw;
    int          pick, e;
    raw = {$urandom, $urandom, $urandom};
    r = raw[$bits(in_t)-1:0];
    if ($urandom_range(99) >= 15) begin
      if (gen_straight_left > 0) begin
        r.near_error = 8'(int'($urandom_range(20)) - 10);
        r.far_error = 8'(int'($urandom_range(20)) - 10);
        gen_straight_left--;
      end else begin
        e = int'($urandom_range(10, 127));
        r.near_error = 8'($urandom_range(1) ? e : -e);
        e = int'($urandom_range(127));
        r.far_error = 8'($urandom_range(1) ? e : -e);
        gen_curve_left--;
        if (gen_curve_left <= 0) begin
          gen_straight_left = int'($urandom_range(6, 24));
          gen_curve_left = int'($urandom_range(2, 8));
        end
      end
      r.near_error_earlier = gen_last_near;
      r.far_error_earlier = gen_last_far;
      pick = int'($urandom_range(99));
      if (pick < 10) begin
        r.left_measured = 16'(int'($urandom_range(69)) - 50);
        r.right_measured = 16'(int'($urandom_range(69)) - 50);
      end else if (pick >= 20) begin
        r.left_measured = 16'(int'($urandom_range(8000)) - 2000);
        r.right_measured = 16'(int'($urandom_range(8000)) - 2000);
      end
      r.stop_request = ($urandom_range(99) < 6);
      r.open_loop_request = ($urandom_range(99) < 6);
    end
    gen_last_near = r.near_error;
    gen_last_far = r.far_error;
    return r;
  endfunction

  function automatic logic [31:0] rand_pair();
    return {16'(int'($urandom_range(9000)) - 3000), 16'(int'($urandom_range(9000)) - 3000)};
  endfunction

  task automatic offer(input in_t req, input bit typed, input out_t want);
    out_t guess;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    guess = next_duties(req);
    expected_duties.push_back(typed ? want : guess);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_duties.size() != 0) @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  // all eight indexes in turn, the spare one included
  task automatic load_regs(input logic [31:0] regs [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= regs[i];
      @(negedge clk);
    end
    cfg_write <= 1'b0;
    ctl.kp_gain = regs[CFG_KP][11:0];
    ctl.ki_gain = regs[CFG_KI][11:0];
    ctl.kd_gain = regs[CFG_KD][11:0];
    ctl.drive_limit = regs[CFG_LIMIT][14:0];
    ctl.target_low_pair = regs[CFG_LOW];
    ctl.target_mid_pair = regs[CFG_MID];
    ctl.target_high_pair = regs[CFG_HIGH];
  endtask

  task automatic check_field(input string name, input logic [14:0] want,
                             input logic [14:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_duties.size() == 0) begin
        $error("result with no request pending: %h", out_data);
        mismatch_cnt++;
      end else begin
        want = expected_duties.pop_front();
        check_field("left_forward_duty", want.left_forward_duty, out_data.left_forward_duty);
        check_field("left_reverse_duty", want.left_reverse_duty, out_data.left_reverse_duty);
        check_field("right_forward_duty", want.right_forward_duty,
                    out_data.right_forward_duty);
        check_field("right_reverse_duty", want.right_reverse_duty,
                    out_data.right_reverse_duty);
        check_field("speed_mode", 15'(want.speed_mode), 15'(out_data.speed_mode));
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != holds_asked) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        holds_served++;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [31:0] regs [8];
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;

    ctl.kp_gain = 12'd480;
    ctl.ki_gain = 12'd96;
    ctl.kd_gain = 12'd0;
    ctl.drive_limit = 15'd9000;
    ctl.target_low_pair = '0;
    ctl.target_mid_pair = '0;
    ctl.target_high_pair = '0;
    left_drv = '0;
    right_drv = '0;
    left_e_last = '0;
    left_e_prev = '0;
    right_e_last = '0;
    right_e_prev = '0;
    near_run = '0;
    far_run = '0;
    straight_on = 1'b0;
    turn_on = 1'b0;

    // stop, open loop over stop, slow wheels
    tick_rows.push_back('{mk(0, 0, 0, 0, 100, 100, 1, 0), 1'b1,
                          '{15'd0, 15'd500, 15'd0, 15'd500, MODE_LOW}});
    tick_rows.push_back('{mk(0, 0, 0, 0, 100, 100, 1, 1), 1'b1,
                          '{15'd4000, 15'd0, 15'd4000, 15'd0, MODE_LOW}});
    tick_rows.push_back('{mk(0, 0, 0, 0, 19, -32768, 0, 1), 1'b1,
                          '{15'd0, 15'd0, 15'd0, 15'd0, MODE_LOW}});
    // field extremes, threshold edges, differential both ways
    tick_rows.push_back('{mk(-128, -128, 127, 127, -32768, 32767, 0, 0), 1'b0, '0});
    tick_rows.push_back('{mk(127, 127, -128, -128, 32767, -32768, 0, 0), 1'b0, '0});
    tick_rows.push_back('{mk(10, 10, 10, 10, 20, 19, 0, 0), 1'b0, '0});
    tick_rows.push_back('{mk(-10, -10, -10, -10, 19, 20, 0, 0), 1'b0, '0});
    tick_rows.push_back('{mk(11, -11, 11, -11, 500, 500, 0, 0), 1'b0, '0});
    tick_rows.push_back('{mk(-11, 11, -11, 11, 500, 500, 0, 0), 1'b0, '0});
    // straight run long enough to set the straight mark, then a turn
    for (int i = 0; i < 8; i++)
      tick_rows.push_back('{mk(0, 0, 0, 0, 300, 300, 0, 0), 1'b0, '0});
    tick_rows.push_back('{mk(10, -10, 0, 0, 300, 300, 0, 0), 1'b0, '0});
    tick_rows.push_back('{mk(0, 0, 0, 0, 300, 300, 0, 0), 1'b0, '0});
    tick_rows.push_back('{mk(0, 0, 12, -12, 300, 300, 0, 0), 1'b0, '0});
    tick_rows.push_back('{mk(0, 0, 0, 0, -1, -1, 0, 0), 1'b0, '0});
    tick_rows.push_back('{mk(-1, -1, -1, -1, -1, -1, 1, 1), 1'b0, '0});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (tick_rows[i]) offer(tick_rows[i].req, tick_rows[i].typed, tick_rows[i].want);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        drain();
        for (int i = 0; i < 8; i++) regs[i] = $urandom;
        case (ph)
          4: begin
            regs[CFG_KP] = regs[CFG_KP] | 32'hFFF;
            regs[CFG_KI] = regs[CFG_KI] | 32'hFFF;
            regs[CFG_KD] = regs[CFG_KD] | 32'hFFF;
            regs[CFG_LIMIT] = regs[CFG_LIMIT] | 32'h7FFF;
            regs[CFG_LOW] = 32'h8000_7FFF;
            regs[CFG_MID] = 32'h7FFF_8000;
            regs[CFG_HIGH] = 32'h7FFF_7FFF;
          end
          5: begin
            regs[CFG_KP] = regs[CFG_KP] & ~32'hFFF;
            regs[CFG_KI] = regs[CFG_KI] & ~32'hFFF;
            regs[CFG_KD] = regs[CFG_KD] & ~32'hFFF;
            regs[CFG_LIMIT] = regs[CFG_LIMIT] & ~32'h7FFF;
            regs[CFG_LOW] = '0;
            regs[CFG_MID] = 32'h8000_8000;
            regs[CFG_HIGH] = '0;
          end
          default: begin
            regs[CFG_KP] = (regs[CFG_KP] & ~32'hFFF) | $urandom_range(1500);
            regs[CFG_KI] = (regs[CFG_KI] & ~32'hFFF) | $urandom_range(600);
            regs[CFG_KD] = (regs[CFG_KD] & ~32'hFFF) | $urandom_range(400);
            regs[CFG_LIMIT] = (regs[CFG_LIMIT] & ~32'h7FFF) | $urandom_range(200, 32767);
            regs[CFG_LOW] = rand_pair();
            regs[CFG_MID] = rand_pair();
            regs[CFG_HIGH] = rand_pair();
          end
        endcase
        load_regs(regs);
      end
      send_idle_pct = (ph % 4 == 1) ? 45 : ((ph % 4 == 3) ? 21 : 0);
      stall_pct = (ph % 4 == 2) ? 45 : ((ph % 4 == 3) ? 21 : 0);
      for (int n = 0; n < PHASE_TICKS; n++) begin
        if (ph == 1 && n == 80) holds_asked++;
        if (ph == 3 && n == 120) drain();
        offer(rand_req(), 1'b0, '0);
      end
    end
    drain();

    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: dual_motor_incremental_pid.f
sv/dmip_pkg.sv
sv/dmip_seq.sv
sv/dmip_dpath.sv
sv/dual_motor_incremental_pid.sv
test/dual_motor_incremental_pid_tb.sv
